FILE: hw/rtl/nine_slice_strip_generator_unit_macros.svh
`ifndef NINE_SLICE_STRIP_GENERATOR_UNIT_MACROS_SVH
`define NINE_SLICE_STRIP_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication on the rising clock edge, off while in reset
`define NSG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nsg check failed");

// next-cycle implication on the rising clock edge, off while in reset
`define NSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nsg check failed");

`endif

FILE: hw/rtl/nsg_pkg.sv
package nsg_pkg;

	localparam int unsigned INDEX_LIMIT = 65535;

	localparam int POS_W     = 24;
	localparam int UV_W      = 17;
	localparam int BORD_W    = 17;
	localparam int TSIZE_W   = 15;
	localparam int COLOR_W   = 32;
	localparam int IDX_W     = 16;
	localparam int NV_W      = 17;
	localparam int STEP_W    = 4;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [UV_W-1:0] UV_ONE = 17'h10000;

	typedef logic [STEP_W-1:0] step_t;

	// microprogram addresses
	localparam step_t S_IDLE  = 4'd0;
	localparam step_t S_MUL_L = 4'd1;
	localparam step_t S_MUL_R = 4'd2;
	localparam step_t S_MUL_T = 4'd3;
	localparam step_t S_MUL_B = 4'd4;
	localparam step_t S_EDGE  = 4'd5;
	localparam step_t S_PART  = 4'd6;
	localparam step_t S_VERT  = 4'd7;
	localparam step_t S_SCHK  = 4'd8;
	localparam step_t S_ST0   = 4'd9;
	localparam step_t S_ST1   = 4'd10;
	localparam step_t S_ZIG0  = 4'd11;
	localparam step_t S_ZIG1  = 4'd12;
	localparam step_t S_NXT   = 4'd13;
	localparam step_t S_DEG0  = 4'd14;
	localparam step_t S_DEG1  = 4'd15;

	typedef enum logic [1:0] {
		BSEL_LEFT,
		BSEL_RIGHT,
		BSEL_TOP,
		BSEL_BOTTOM
	} bsel_t;

	typedef enum logic {
		KIND_VERTEX = 1'b0,
		KIND_INDEX  = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		IDX_BASE_M1,
		IDX_BASE,
		IDX_ROW_END,
		IDX_ROW,
		IDX_COL,
		IDX_COL_NEXT
	} idx_sel_t;

	typedef enum logic [1:0] {
		CNT_NONE,
		CNT_VERT,
		CNT_COL,
		CNT_STRIPE
	} cnt_op_t;

	typedef enum logic [2:0] {
		JC_ALWAYS,
		JC_NO_INPUT,
		JC_BASE_ZERO,
		JC_VERT_MORE,
		JC_COL_MORE,
		JC_STRIPE_MORE
	} jc_t;

	typedef enum logic [1:0] {
		REG_TEX_W,
		REG_TEX_H,
		REG_COLOR
	} reg_idx_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		bsel_t    mul_sel;
		logic     edge_en;
		logic     part_en;
		logic     emit;
		kind_t    kind;
		idx_sel_t idx_sel;
		cnt_op_t  cnt_op;
		jc_t      jc;
		step_t    tgt_t;
		step_t    tgt_f;
	} uword_t;

	typedef struct packed {
		logic out_free;
		logic base_zero;
		logic vert_more;
		logic col_more;
		logic stripe_more;
	} dp_status_t;

	typedef struct packed {
		logic [TSIZE_W-1:0] tex_w;
		logic [TSIZE_W-1:0] tex_h;
		logic [COLOR_W-1:0] color;
	} cfg_t;

endpackage

FILE: hw/rtl/nine_slice_strip_generator_unit.sv
// first vertex: the input transaction is followed by four border-width steps on the
//   shared multiplier, the edge step, the part step and then the first vertex step,
//   which fills the output register; the next rectangle is taken only once the
//   sequencer is back idle after the last stripe, and emitting steps wait on out_stall
// reset: registers back to texture size 1 and white, vertex counter cleared, sequencer idle
module nine_slice_strip_generator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [nsg_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [nsg_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [nsg_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_left,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_top,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_right,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_bottom,
	input  logic [nsg_pkg::UV_W-1:0]            tex_left,
	input  logic [nsg_pkg::UV_W-1:0]            tex_top,
	input  logic [nsg_pkg::UV_W-1:0]            tex_right,
	input  logic [nsg_pkg::UV_W-1:0]            tex_bottom,
	input  logic [nsg_pkg::BORD_W-1:0]          border_left,
	input  logic [nsg_pkg::BORD_W-1:0]          border_top,
	input  logic [nsg_pkg::BORD_W-1:0]          border_right,
	input  logic [nsg_pkg::BORD_W-1:0]          border_bottom,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                item_kind,
	output logic signed [nsg_pkg::POS_W-1:0]    vert_x,
	output logic signed [nsg_pkg::POS_W-1:0]    vert_y,
	output logic [nsg_pkg::UV_W-1:0]            vert_u,
	output logic [nsg_pkg::UV_W-1:0]            vert_v,
	output logic [nsg_pkg::COLOR_W-1:0]         vert_color,
	output logic [nsg_pkg::IDX_W-1:0]           strip_index,
	output logic                                new_part,
	output logic                                last_result
);
	import nsg_pkg::*;

	cfg_t       cfg;
	uword_t     ctrl;
	dp_status_t sts;
	logic       go;

	nsg_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nsg_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.ctrl     (ctrl),
		.go       (go)
	);

	// a transaction is taken only on the idle step of the microprogram
	assign in_stall = !ctrl.load;

	nsg_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.go            (go),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.pos_left      (pos_left),
		.pos_top       (pos_top),
		.pos_right     (pos_right),
		.pos_bottom    (pos_bottom),
		.tex_left      (tex_left),
		.tex_top       (tex_top),
		.tex_right     (tex_right),
		.tex_bottom    (tex_bottom),
		.border_left   (border_left),
		.border_top    (border_top),
		.border_right  (border_right),
		.border_bottom (border_bottom),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.item_kind     (item_kind),
		.vert_x        (vert_x),
		.vert_y        (vert_y),
		.vert_u        (vert_u),
		.vert_v        (vert_v),
		.vert_color    (vert_color),
		.strip_index   (strip_index),
		.new_part      (new_part),
		.last_result   (last_result)
	);

endmodule

FILE: hw/rtl/nsg_ucode_rom.sv
module nsg_ucode_rom (
	input  nsg_pkg::step_t  addr,
	output nsg_pkg::uword_t word
);
	import nsg_pkg::*;

	always_comb begin
		word = '0;
		word.jc = JC_ALWAYS;
		word.tgt_t = S_IDLE;
		word.tgt_f = S_IDLE;
		unique case (addr)
			S_IDLE: begin
				word.load = 1'b1;
				word.jc = JC_NO_INPUT;
				word.tgt_t = S_IDLE;
				word.tgt_f = S_MUL_L;
			end
			S_MUL_L: begin
				word.mul_en = 1'b1;
				word.mul_sel = BSEL_LEFT;
				word.tgt_t = S_MUL_R;
			end
			S_MUL_R: begin
				word.mul_en = 1'b1;
				word.mul_sel = BSEL_RIGHT;
				word.tgt_t = S_MUL_T;
			end
			S_MUL_T: begin
				word.mul_en = 1'b1;
				word.mul_sel = BSEL_TOP;
				word.tgt_t = S_MUL_B;
			end
			S_MUL_B: begin
				word.mul_en = 1'b1;
				word.mul_sel = BSEL_BOTTOM;
				word.tgt_t = S_EDGE;
			end
			S_EDGE: begin
				word.edge_en = 1'b1;
				word.tgt_t = S_PART;
			end
			S_PART: begin
				word.part_en = 1'b1;
				word.tgt_t = S_VERT;
			end
			S_VERT: begin
				word.emit = 1'b1;
				word.kind = KIND_VERTEX;
				word.cnt_op = CNT_VERT;
				word.jc = JC_VERT_MORE;
				word.tgt_t = S_VERT;
				word.tgt_f = S_SCHK;
			end
			S_SCHK: begin
				word.jc = JC_BASE_ZERO;
				word.tgt_t = S_ZIG0;
				word.tgt_f = S_ST0;
			end
			S_ST0: begin
				word.emit = 1'b1;
				word.kind = KIND_INDEX;
				word.idx_sel = IDX_BASE_M1;
				word.tgt_t = S_ST1;
			end
			S_ST1: begin
				word.emit = 1'b1;
				word.kind = KIND_INDEX;
				word.idx_sel = IDX_BASE;
				word.tgt_t = S_ZIG0;
			end
			S_ZIG0: begin
				word.emit = 1'b1;
				word.kind = KIND_INDEX;
				word.idx_sel = IDX_COL;
				word.tgt_t = S_ZIG1;
			end
			S_ZIG1: begin
				word.emit = 1'b1;
				word.kind = KIND_INDEX;
				word.idx_sel = IDX_COL_NEXT;
				word.cnt_op = CNT_COL;
				word.jc = JC_COL_MORE;
				word.tgt_t = S_ZIG0;
				word.tgt_f = S_NXT;
			end
			S_NXT: begin
				word.cnt_op = CNT_STRIPE;
				word.jc = JC_STRIPE_MORE;
				word.tgt_t = S_DEG0;
				word.tgt_f = S_IDLE;
			end
			S_DEG0: begin
				word.emit = 1'b1;
				word.kind = KIND_INDEX;
				word.idx_sel = IDX_ROW_END;
				word.tgt_t = S_DEG1;
			end
			S_DEG1: begin
				word.emit = 1'b1;
				word.kind = KIND_INDEX;
				word.idx_sel = IDX_ROW;
				word.tgt_t = S_ZIG0;
			end
			default: begin
				word.load = 1'b1;
				word.jc = JC_NO_INPUT;
				word.tgt_t = S_IDLE;
				word.tgt_f = S_MUL_L;
			end
		endcase
	end

endmodule

FILE: hw/rtl/nsg_sequencer.sv
`include "nine_slice_strip_generator_unit_macros.svh"

module nsg_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  nsg_pkg::dp_status_t sts,
	output nsg_pkg::uword_t     ctrl,
	output logic                go
);
	import nsg_pkg::*;

	step_t  pc_q;
	uword_t word;
	logic   taken;

	nsg_ucode_rom u_rom (
		.addr (pc_q),
		.word (word)
	);

	assign ctrl = word;

	// an emitting step waits for room in the output register
	assign go = !word.emit || sts.out_free;

	always_comb begin
		unique case (word.jc)
			JC_ALWAYS:      taken = 1'b1;
			JC_NO_INPUT:    taken = !in_valid;
			JC_BASE_ZERO:   taken = sts.base_zero;
			JC_VERT_MORE:   taken = sts.vert_more;
			JC_COL_MORE:    taken = sts.col_more;
			JC_STRIPE_MORE: taken = sts.stripe_more;
			default:        taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (go) begin
			pc_q <= taken ? word.tgt_t : word.tgt_f;
		end
	end

	`NSG_ASSERT_NEXT(a_part_follows_edge, clk, arst_n, go && word.edge_en, word.part_en)

endmodule

FILE: hw/rtl/nsg_apb_regs.sv
module nsg_apb_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [nsg_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [nsg_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [nsg_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready,
	output nsg_pkg::cfg_t                      cfg
);
	import nsg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tex_w <= TSIZE_W'(1);
			cfg_q.tex_h <= TSIZE_W'(1);
			cfg_q.color <= '1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_TEX_W: cfg_q.tex_w <= pwdata[TSIZE_W-1:0];
				REG_TEX_H: cfg_q.tex_h <= pwdata[TSIZE_W-1:0];
				REG_COLOR: cfg_q.color <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_TEX_W: prdata = CFG_DATA_W'(cfg_q.tex_w);
			REG_TEX_H: prdata = CFG_DATA_W'(cfg_q.tex_h);
			REG_COLOR: prdata = CFG_DATA_W'(cfg_q.color);
			default:   prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/nsg_datapath.sv
`include "nine_slice_strip_generator_unit_macros.svh"

module nsg_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nsg_pkg::uword_t                     ctrl,
	input  logic                                go,
	input  nsg_pkg::cfg_t                       cfg,
	input  logic                                in_valid,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_left,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_top,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_right,
	input  logic signed [nsg_pkg::POS_W-1:0]    pos_bottom,
	input  logic [nsg_pkg::UV_W-1:0]            tex_left,
	input  logic [nsg_pkg::UV_W-1:0]            tex_top,
	input  logic [nsg_pkg::UV_W-1:0]            tex_right,
	input  logic [nsg_pkg::UV_W-1:0]            tex_bottom,
	input  logic [nsg_pkg::BORD_W-1:0]          border_left,
	input  logic [nsg_pkg::BORD_W-1:0]          border_top,
	input  logic [nsg_pkg::BORD_W-1:0]          border_right,
	input  logic [nsg_pkg::BORD_W-1:0]          border_bottom,
	output nsg_pkg::dp_status_t                 sts,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                item_kind,
	output logic signed [nsg_pkg::POS_W-1:0]    vert_x,
	output logic signed [nsg_pkg::POS_W-1:0]    vert_y,
	output logic [nsg_pkg::UV_W-1:0]            vert_u,
	output logic [nsg_pkg::UV_W-1:0]            vert_v,
	output logic [nsg_pkg::COLOR_W-1:0]         vert_color,
	output logic [nsg_pkg::IDX_W-1:0]           strip_index,
	output logic                                new_part,
	output logic                                last_result
);
	import nsg_pkg::*;

	function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W+1:0] v);
		logic [POS_W-1:0] r;
		if (v[POS_W+1] == v[POS_W] && v[POS_W] == v[POS_W-1]) begin
			r = v[POS_W-1:0];
		end else if (v[POS_W+1]) begin
			r = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(POS_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [UV_W-1:0] sat_uv(input logic [UV_W+1:0] v);
		logic [UV_W-1:0] r;
		if (v[UV_W+1]) begin
			r = '0;
		end else if (v[UV_W:0] > {1'b0, UV_ONE}) begin
			r = UV_ONE;
		end else begin
			r = v[UV_W-1:0];
		end
		return r;
	endfunction

	// captured rectangle
	logic [POS_W-1:0]  pos_l_q, pos_t_q, pos_r_q, pos_b_q;
	logic [UV_W-1:0]   tex_l_q, tex_t_q, tex_r_q, tex_b_q;
	logic [BORD_W-1:0] bord_q [4];

	// shared width multiplier
	logic [TSIZE_W-1:0] mul_size;
	logic [31:0]        mul_prod;
	logic [31:0]        mul_round;
	logic [POS_W-1:0]   wid_q [4];

	// slice edges
	logic              has_l, has_r, has_t, has_b;
	logic [POS_W-1:0]  x_in_l, x_in_r, y_in_t, y_in_b;
	logic [UV_W-1:0]   u_in_l, u_in_r, v_in_t, v_in_b;
	logic [POS_W-1:0]  col_x_q [4];
	logic [UV_W-1:0]   col_u_q [4];
	logic [POS_W-1:0]  row_y_q [4];
	logic [UV_W-1:0]   row_v_q [4];
	logic [2:0]        ncol_q, nrow_q;
	logic [1:0]        ncol_m1, nrow_m1, stripe_last;

	// part bookkeeping and walk counters
	logic [4:0]        vcount;
	logic              overflow;
	logic [NV_W-1:0]   base;
	logic [NV_W-1:0]   next_vertex_q;
	logic [IDX_W-1:0]  base_q, row_q;
	logic              np_q;
	logic [1:0]        i_q, j_q, c_q, s_q;
	logic [IDX_W-1:0]  idx_val;
	logic [NV_W-1:0]   idx_ext;
	logic              last_flag;
	logic              out_free;
	logic              emit_go;

	// output register
	logic              out_valid_q;
	logic              kind_q;
	logic [POS_W-1:0]  x_q, y_q;
	logic [UV_W-1:0]   u_q, v_q;
	logic [COLOR_W-1:0] color_q;
	logic [IDX_W-1:0]  idx_q;
	logic              np_out_q;
	logic              last_q;

	always_ff @(posedge clk) begin
		if (ctrl.load && in_valid) begin
			pos_l_q <= pos_left;
			pos_t_q <= pos_top;
			pos_r_q <= pos_right;
			pos_b_q <= pos_bottom;
			tex_l_q <= tex_left;
			tex_t_q <= tex_top;
			tex_r_q <= tex_right;
			tex_b_q <= tex_bottom;
			bord_q[BSEL_LEFT] <= border_left;
			bord_q[BSEL_RIGHT] <= border_right;
			bord_q[BSEL_TOP] <= border_top;
			bord_q[BSEL_BOTTOM] <= border_bottom;
		end
	end

	// pixel width of one border, rounded to the Q16.8 grid
	always_comb begin
		if (ctrl.mul_sel == BSEL_LEFT || ctrl.mul_sel == BSEL_RIGHT) begin
			mul_size = cfg.tex_w;
		end else begin
			mul_size = cfg.tex_h;
		end
		mul_prod = 32'(bord_q[ctrl.mul_sel]) * 32'(mul_size);
		mul_round = mul_prod + 32'd128;
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.mul_en) begin
			wid_q[ctrl.mul_sel] <= mul_round[POS_W+7:8];
		end
	end

	always_comb begin
		has_l = wid_q[BSEL_LEFT] != '0;
		has_r = wid_q[BSEL_RIGHT] != '0;
		has_t = wid_q[BSEL_TOP] != '0;
		has_b = wid_q[BSEL_BOTTOM] != '0;
		x_in_l = sat_pos({{2{pos_l_q[POS_W-1]}}, pos_l_q} + {2'b00, wid_q[BSEL_LEFT]});
		x_in_r = sat_pos({{2{pos_r_q[POS_W-1]}}, pos_r_q} - {2'b00, wid_q[BSEL_RIGHT]});
		y_in_t = sat_pos({{2{pos_t_q[POS_W-1]}}, pos_t_q} + {2'b00, wid_q[BSEL_TOP]});
		y_in_b = sat_pos({{2{pos_b_q[POS_W-1]}}, pos_b_q} - {2'b00, wid_q[BSEL_BOTTOM]});
		u_in_l = sat_uv({2'b00, tex_l_q} + {2'b00, bord_q[BSEL_LEFT]});
		u_in_r = sat_uv({2'b00, tex_r_q} - {2'b00, bord_q[BSEL_RIGHT]});
		v_in_t = sat_uv({2'b00, tex_t_q} + {2'b00, bord_q[BSEL_TOP]});
		v_in_b = sat_uv({2'b00, tex_b_q} - {2'b00, bord_q[BSEL_BOTTOM]});
	end

	// compact the present edges into column and row lists
	always_ff @(posedge clk) begin
		if (go && ctrl.edge_en) begin
			col_x_q[0] <= pos_l_q;
			col_u_q[0] <= sat_uv({2'b00, tex_l_q});
			col_x_q[1] <= has_l ? x_in_l : (has_r ? x_in_r : pos_r_q);
			col_u_q[1] <= has_l ? u_in_l : (has_r ? u_in_r : sat_uv({2'b00, tex_r_q}));
			col_x_q[2] <= (has_l && has_r) ? x_in_r : pos_r_q;
			col_u_q[2] <= (has_l && has_r) ? u_in_r : sat_uv({2'b00, tex_r_q});
			col_x_q[3] <= pos_r_q;
			col_u_q[3] <= sat_uv({2'b00, tex_r_q});
			row_y_q[0] <= pos_t_q;
			row_v_q[0] <= sat_uv({2'b00, tex_t_q});
			row_y_q[1] <= has_t ? y_in_t : (has_b ? y_in_b : pos_b_q);
			row_v_q[1] <= has_t ? v_in_t : (has_b ? v_in_b : sat_uv({2'b00, tex_b_q}));
			row_y_q[2] <= (has_t && has_b) ? y_in_b : pos_b_q;
			row_v_q[2] <= (has_t && has_b) ? v_in_b : sat_uv({2'b00, tex_b_q});
			row_y_q[3] <= pos_b_q;
			row_v_q[3] <= sat_uv({2'b00, tex_b_q});
			ncol_q <= 3'd2 + {2'b00, has_l} + {2'b00, has_r};
			nrow_q <= 3'd2 + {2'b00, has_t} + {2'b00, has_b};
		end
	end

	assign ncol_m1 = 2'(ncol_q - 3'd1);
	assign nrow_m1 = 2'(nrow_q - 3'd1);
	assign stripe_last = 2'(nrow_q - 3'd2);

	always_comb begin
		vcount = 5'({2'b00, ncol_q} * {2'b00, nrow_q});
		overflow = ({1'b0, next_vertex_q} + 18'(vcount)) > 18'(INDEX_LIMIT);
		base = overflow ? '0 : next_vertex_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_vertex_q <= '0;
		end else if (go && ctrl.part_en) begin
			next_vertex_q <= base + NV_W'(vcount);
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.part_en) begin
			base_q <= base[IDX_W-1:0];
			row_q <= base[IDX_W-1:0];
			np_q <= overflow;
			i_q <= '0;
			j_q <= '0;
			c_q <= '0;
			s_q <= '0;
		end else if (go) begin
			case (ctrl.cnt_op)
				CNT_VERT: begin
					if (j_q == ncol_m1) begin
						j_q <= '0;
						i_q <= i_q + 2'd1;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				CNT_COL: c_q <= c_q + 2'd1;
				CNT_STRIPE: begin
					row_q <= row_q + IDX_W'(ncol_q);
					s_q <= s_q + 2'd1;
					c_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ctrl.idx_sel)
			IDX_BASE_M1:  idx_val = base_q - IDX_W'(1);
			IDX_BASE:     idx_val = base_q;
			IDX_ROW_END:  idx_val = row_q + IDX_W'(ncol_m1);
			IDX_ROW:      idx_val = row_q;
			IDX_COL:      idx_val = row_q + IDX_W'(c_q);
			IDX_COL_NEXT: idx_val = row_q + IDX_W'(c_q) + IDX_W'(ncol_q);
			default:      idx_val = '0;
		endcase
	end

	assign idx_ext = NV_W'(idx_val);

	assign sts.out_free = out_free;
	assign sts.base_zero = base_q == '0;
	assign sts.vert_more = !(i_q == nrow_m1 && j_q == ncol_m1);
	assign sts.col_more = c_q != ncol_m1;
	assign sts.stripe_more = s_q != stripe_last;

	assign last_flag = (ctrl.idx_sel == IDX_COL_NEXT) && !sts.col_more && !sts.stripe_more;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_go = go && ctrl.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			kind_q <= ctrl.kind;
			np_out_q <= np_q;
			if (ctrl.kind == KIND_VERTEX) begin
				x_q <= col_x_q[j_q];
				y_q <= row_y_q[i_q];
				u_q <= col_u_q[j_q];
				v_q <= row_v_q[i_q];
				color_q <= cfg.color;
				idx_q <= '0;
				last_q <= 1'b0;
			end else begin
				x_q <= '0;
				y_q <= '0;
				u_q <= '0;
				v_q <= '0;
				color_q <= '0;
				idx_q <= idx_val;
				last_q <= last_flag;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign item_kind = kind_q;
	assign vert_x = x_q;
	assign vert_y = y_q;
	assign vert_u = u_q;
	assign vert_v = v_q;
	assign vert_color = color_q;
	assign strip_index = idx_q;
	assign new_part = np_out_q;
	assign last_result = last_q;

	`NSG_ASSERT_SAME(a_nv_in_range, clk, arst_n, 1'b1, next_vertex_q <= NV_W'(INDEX_LIMIT))
	`NSG_ASSERT_SAME(a_vert_walk, clk, arst_n, go && ctrl.cnt_op == CNT_VERT, j_q <= ncol_m1 && i_q <= nrow_m1)
	`NSG_ASSERT_SAME(a_idx_in_part, clk, arst_n, emit_go && ctrl.kind == KIND_INDEX, idx_ext < next_vertex_q)

endmodule
